// ----- rtl/eta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased tween animator package
// Shared types, command codes and fixed-point constants.
// ----------------------------------------------------------------------------
package eta_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int TIME_BITS_DEF  = 16;

  localparam int T_FRAC = 16;
  localparam int EW     = 20;
  localparam int MB     = 18;

  localparam logic signed [EW-1:0] E_ONE = 20'sd65536;
  localparam logic [MB-1:0] C1_Q16 = 18'd111515;
  localparam logic [MB-1:0] C3_Q16 = 18'd177051;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [2:0] CRV_LINEAR      = 3'd0;
  localparam logic [2:0] CRV_IN_QUAD     = 3'd1;
  localparam logic [2:0] CRV_OUT_QUAD    = 3'd2;
  localparam logic [2:0] CRV_INOUT_QUAD  = 3'd3;
  localparam logic [2:0] CRV_OUT_CUBIC   = 3'd4;
  localparam logic [2:0] CRV_INOUT_CUBIC = 3'd5;
  localparam logic [2:0] CRV_OUT_BACK    = 3'd6;

  localparam logic [2:0] STEP_A = 3'd0;
  localparam logic [2:0] STEP_B = 3'd1;
  localparam logic [2:0] STEP_C = 3'd2;
  localparam logic [2:0] STEP_D = 3'd3;
  localparam logic [2:0] STEP_E = 3'd4;
  localparam logic [2:0] STEP_F = 3'd5;

  localparam int DIV_STEPS  = 16;
  localparam int EASE_STEPS = 6;
  localparam int LERP_STEPS = 3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK,
    OP_DIV,
    OP_EASE,
    OP_LERP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic snap;
  } sts_t;

endpackage

// ----- rtl/eta_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased tween animator controller
// Sequences load, tick, divide, easing and interpolation steps.
// ----------------------------------------------------------------------------
module eta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          action_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  output logic          out_load_o,
  input  eta_pkg::sts_t sts_i,
  output eta_pkg::cmd_t cmd_o
);
  import eta_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_EASE = 3'd2;
  localparam logic [2:0] S_LERP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o.op    = OP_NONE;
    cmd_o.step  = cnt_q[2:0];
    out_load_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_START) begin
            cmd_o.op = OP_LOAD;
            state_d  = S_DONE;
          end else if (sts_i.busy) begin
            cmd_o.op = OP_TICK;
            cnt_d    = '0;
            state_d  = sts_i.snap ? S_DONE : S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (cnt_q == 4'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_EASE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_EASE: begin
        cmd_o.op = OP_EASE;
        if (cnt_q == 4'(EASE_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_LERP;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_LERP: begin
        cmd_o.op = OP_LERP;
        if (cnt_q == 4'(LERP_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_div_to_ease: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == 4'(DIV_STEPS - 1)) |=> (state_q == S_EASE && cnt_q == '0))
    else $error("divide did not hand over to easing");

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i && action_i == ACT_START) |=> (state_q == S_DONE))
    else $error("start transaction did not finish at once");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EASE) |-> (cnt_q < 4'(EASE_STEPS))) and
    ((state_q == S_LERP) |-> (cnt_q < 4'(LERP_STEPS))))
    else $error("step counter out of range");

endmodule

// ----- rtl/eta_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased tween animator datapath
// Time accumulation, serial divider, shared multiplier, easing and lerp.
// ----------------------------------------------------------------------------
module eta_dp #(
  parameter int VALUE_BITS = eta_pkg::VALUE_BITS_DEF,
  parameter int TIME_BITS  = eta_pkg::TIME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  eta_pkg::cmd_t                cmd_i,
  output eta_pkg::sts_t                sts_o,
  input  logic signed [VALUE_BITS-1:0] start_value_i,
  input  logic signed [VALUE_BITS-1:0] end_value_i,
  input  logic [TIME_BITS-1:0]         span_ms_i,
  input  logic [2:0]                   curve_i,
  input  logic signed [8:0]            loop_count_i,
  input  logic [TIME_BITS-1:0]         delta_ms_i,
  output logic signed [VALUE_BITS-1:0] current_value_o,
  output logic                         running_o
);
  import eta_pkg::*;

  localparam int V  = VALUE_BITS;
  localparam int T  = TIME_BITS;
  localparam int SW = T + 2;
  localparam int MA = (V - 15 > 33) ? V - 15 : 33;
  localparam int PW = MA + MB;
  localparam int RW = PW + 2;

  localparam logic [SW-1:0] SPENT_MAX = '1;
  localparam logic signed [RW-1:0] VMAX_X = $signed({{(RW-V+1){1'b0}}, {(V-1){1'b1}}});
  localparam logic signed [RW-1:0] VMIN_X = -VMAX_X - 1;
  localparam logic signed [V-1:0]  VMAX_V = $signed({1'b0, {(V-1){1'b1}}});
  localparam logic signed [V-1:0]  VMIN_V = $signed({1'b1, {(V-1){1'b0}}});

  logic signed [V-1:0] from_q, to_q, now_q;
  logic [T-1:0]        len_q;
  logic [SW-1:0]       spent_q;
  logic [2:0]          curve_q;
  logic signed [8:0]   loops_q;
  logic                busy_q;
  logic [T-1:0]        rem_q;
  logic [15:0]         quo_q;
  logic                full_q;
  logic [PW-1:0]       p_q;
  logic [16:0]         m2_q, m3_q;
  logic signed [EW-1:0] e_q;
  logic [18:0]         lor_q;

  // tick arithmetic
  logic [SW:0]   sum_w;
  logic [SW-1:0] sat_w, sp_w, len_x;
  logic          wrap_w, snap_w;

  assign len_x  = {2'b00, len_q};
  assign sum_w  = {1'b0, spent_q} + {3'b000, delta_ms_i};
  assign sat_w  = sum_w[SW] ? SPENT_MAX : sum_w[SW-1:0];
  assign wrap_w = (sat_w >= len_x);
  assign snap_w = wrap_w && (loops_q == '0);
  assign sp_w   = wrap_w ? (sat_w - len_x) : sat_w;

  // divider step
  logic [T:0] r2_w, r2s_w;
  logic       ge_w;

  assign r2_w  = {rem_q, 1'b0};
  assign ge_w  = (r2_w >= {1'b0, len_q});
  assign r2s_w = r2_w - {1'b0, len_q};

  // easing operands
  logic [16:0] t_w, m_w;
  logic [17:0] w_w, tq2_w, t2x_w;
  logic [18:0] t4m_w;
  logic        half_w;

  assign t_w    = full_q ? 17'h10000 : {1'b0, quo_q};
  assign half_w = (t_w < 17'd32768);
  assign m_w    = 17'h10000 - t_w;
  assign t2x_w  = {t_w, 1'b0};
  assign w_w    = 18'h20000 - t2x_w;
  assign tq2_w  = 18'h20000 - {1'b0, t_w};
  assign t4m_w  = 19'h40000 - {1'b0, t2x_w};

  // rounded shifts of the product register
  logic [PW:0]      p_x;
  logic [PW:0]      p16_w, p30_w, p32_w, p33_w;
  logic signed [EW-1:0] r16_e, r30_e, r32_e, r33_e;

  assign p_x   = {1'b0, p_q};
  assign p16_w = (p_x + (PW+1)'(1 << 15)) >> 16;
  assign p30_w = (p_x + (PW+1)'(1 << 29)) >> 30;
  assign p32_w = (p_x + (PW+1)'(64'd1 << 31)) >> 32;
  assign p33_w = (p_x + (PW+1)'(64'd1 << 32)) >> 33;
  assign r16_e = $signed({1'b0, p16_w[EW-2:0]});
  assign r30_e = $signed({1'b0, p30_w[EW-2:0]});
  assign r32_e = $signed({1'b0, p32_w[EW-2:0]});
  assign r33_e = $signed({1'b0, p33_w[EW-2:0]});

  // lerp operands
  logic signed [V:0]    d_w;
  logic [V:0]           dm_w;
  logic signed [EW-1:0] ne_w;
  logic [MB-1:0]        em_w;
  logic                 neg_w;
  logic [PW:0]          r_w;
  logic signed [RW-1:0] from_x, r_x, res_w;
  logic signed [V-1:0]  lerp_w;

  assign d_w    = {to_q[V-1], to_q} - {from_q[V-1], from_q};
  assign dm_w   = d_w[V] ? $unsigned(-d_w) : $unsigned(d_w);
  assign ne_w   = -e_q;
  assign em_w   = e_q[EW-1] ? ne_w[MB-1:0] : e_q[MB-1:0];
  assign neg_w  = d_w[V] ^ e_q[EW-1];
  assign r_w    = p_x + (PW+1)'(lor_q);
  assign from_x = RW'(from_q);
  assign r_x    = $signed({1'b0, r_w});
  assign res_w  = neg_w ? (from_x - r_x) : (from_x + r_x);
  assign lerp_w = (res_w > VMAX_X) ? VMAX_V :
                  (res_w < VMIN_X) ? VMIN_V : res_w[V-1:0];

  // shared multiplier
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [PW-1:0] prod_w;
  logic          mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    if (cmd_i.op == OP_EASE) begin
      case (cmd_i.step)
        STEP_A: begin
          mul_en = 1'b1;
          case (curve_q)
            CRV_IN_QUAD: begin
              mul_a = MA'(t_w);
              mul_b = MB'(t_w);
            end
            CRV_OUT_QUAD: begin
              mul_a = MA'(t_w);
              mul_b = tq2_w;
            end
            CRV_INOUT_QUAD: begin
              mul_a = MA'(t_w);
              mul_b = half_w ? t2x_w : t4m_w[17:0];
            end
            CRV_OUT_CUBIC, CRV_OUT_BACK: begin
              mul_a = MA'(m_w);
              mul_b = MB'(m_w);
            end
            CRV_INOUT_CUBIC: begin
              mul_a = half_w ? MA'(t_w) : MA'(w_w);
              mul_b = half_w ? MB'(t_w) : w_w;
            end
            default: mul_en = 1'b0;
          endcase
        end
        STEP_B: begin
          mul_en = 1'b1;
          mul_a  = MA'(p_q[32:0]);
          case (curve_q)
            CRV_OUT_CUBIC:   mul_b = MB'(m_w);
            CRV_INOUT_CUBIC: mul_b = half_w ? MB'(t_w) : w_w;
            default:         mul_en = 1'b0;
          endcase
        end
        STEP_C: begin
          mul_a  = MA'(m2_q);
          mul_b  = MB'(m_w);
          mul_en = (curve_q == CRV_OUT_BACK);
        end
        STEP_D: begin
          mul_a  = MA'(m2_q);
          mul_b  = C1_Q16;
          mul_en = (curve_q == CRV_OUT_BACK);
        end
        STEP_E: begin
          mul_a  = MA'(m3_q);
          mul_b  = C3_Q16;
          mul_en = (curve_q == CRV_OUT_BACK);
        end
        default: mul_en = 1'b0;
      endcase
    end else if (cmd_i.op == OP_LERP) begin
      mul_b = em_w;
      case (cmd_i.step)
        STEP_A: begin
          mul_a  = MA'(dm_w[15:0]);
          mul_en = 1'b1;
        end
        STEP_B: begin
          mul_a  = MA'(dm_w[V:16]);
          mul_en = 1'b1;
        end
        default: mul_en = 1'b0;
      endcase
    end
  end

  assign prod_w = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_q <= prod_w;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_q  <= '0;
      to_q    <= '0;
      now_q   <= '0;
      len_q   <= T'(1);
      spent_q <= '0;
      curve_q <= CRV_LINEAR;
      loops_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          from_q  <= start_value_i;
          to_q    <= end_value_i;
          now_q   <= start_value_i;
          len_q   <= (span_ms_i == '0) ? T'(1) : span_ms_i;
          spent_q <= '0;
          curve_q <= curve_i;
          loops_q <= loop_count_i;
          busy_q  <= 1'b1;
        end
        OP_TICK: begin
          if (snap_w) begin
            now_q   <= to_q;
            busy_q  <= 1'b0;
            spent_q <= sat_w;
          end else begin
            spent_q <= sp_w;
            if (wrap_w) begin
              from_q <= to_q;
              to_q   <= from_q;
              if (loops_q > 9'sd0) begin
                loops_q <= loops_q - 9'sd1;
              end
            end
          end
        end
        OP_LERP: begin
          if (cmd_i.step == STEP_C) begin
            now_q <= lerp_w;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // divider and easing working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TICK: begin
        rem_q  <= sp_w[T-1:0];
        full_q <= (sp_w >= len_x);
        quo_q  <= '0;
      end
      OP_DIV: begin
        rem_q <= ge_w ? r2s_w[T-1:0] : r2_w[T-1:0];
        quo_q <= {quo_q[14:0], ge_w};
      end
      OP_EASE: begin
        case (cmd_i.step)
          STEP_B: begin
            case (curve_q)
              CRV_IN_QUAD, CRV_OUT_QUAD: e_q <= r16_e;
              CRV_INOUT_QUAD:            e_q <= half_w ? r16_e : r16_e - E_ONE;
              CRV_OUT_BACK:              m2_q <= p16_w[16:0];
              default: begin
              end
            endcase
          end
          STEP_C: begin
            case (curve_q)
              CRV_OUT_CUBIC:   e_q <= E_ONE - r32_e;
              CRV_INOUT_CUBIC: e_q <= half_w ? r30_e : E_ONE - r33_e;
              default: begin
              end
            endcase
          end
          STEP_D: begin
            if (curve_q == CRV_OUT_BACK) begin
              m3_q <= p16_w[16:0];
            end
          end
          STEP_E: begin
            if (curve_q == CRV_OUT_BACK) begin
              e_q <= E_ONE + r16_e;
            end
          end
          STEP_F: begin
            if (t_w == '0) begin
              e_q <= '0;
            end else if (full_q) begin
              e_q <= E_ONE;
            end else if (curve_q == CRV_OUT_BACK) begin
              e_q <= e_q - r16_e;
            end else if (curve_q == CRV_LINEAR || curve_q > CRV_OUT_BACK) begin
              e_q <= $signed({3'b000, t_w});
            end
          end
          default: begin
          end
        endcase
      end
      OP_LERP: begin
        if (cmd_i.step == STEP_B) begin
          lor_q <= p16_w[18:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.busy      = busy_q;
  assign sts_o.snap      = snap_w;
  assign current_value_o = now_q;
  assign running_o       = busy_q;

  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(cmd_i.op == OP_TICK))
    else $error("animation ended outside a tick");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_LOAD) |=> busy_q)
    else $error("load did not start the animation");

  a_snap_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_TICK && snap_w) |=> (now_q == $past(to_q) && !busy_q))
    else $error("final tick did not snap to the end value");

endmodule

// ----- rtl/eased_tween_animator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased tween animator
// Start and tick transactions drive a Q16.16 tween with seven easing curves.
// ----------------------------------------------------------------------------
// A start transaction, an idle tick or a final tick goes from acceptance to
// the done state; an active tick first runs the serial divider, 6 easing
// steps and 3 lerp steps on one shared multiplier. The result then waits
// for a free output register. One transaction at a time, the next accepted
// after the result enters the output register; reset clears control state.
module eased_tween_animator #(
  parameter int VALUE_BITS = eta_pkg::VALUE_BITS_DEF,
  parameter int TIME_BITS  = eta_pkg::TIME_BITS_DEF,
  localparam int InW  = ((2*VALUE_BITS + 2*TIME_BITS + 12 + 7) / 8) * 8,
  localparam int OutW = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // start_value, end_value, span_ms, curve, loop_count, delta_ms
  input  logic [InW-1:0]  s_axis_tdata_i,
  // action
  input  logic            s_axis_tuser_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // current_value
  output logic [OutW-1:0] m_axis_tdata_o,
  // running
  output logic            m_axis_tuser_o
);
  import eta_pkg::*;

  localparam int V = VALUE_BITS;
  localparam int T = TIME_BITS;
  localparam int O_END = V;
  localparam int O_DUR = 2 * V;
  localparam int O_CRV = 2 * V + T;
  localparam int O_LC  = 2 * V + T + 3;
  localparam int O_DT  = 2 * V + T + 12;

  cmd_t cmd;
  sts_t sts;
  logic out_load, out_free;
  logic signed [V-1:0] cur_value;
  logic                running;

  logic                out_valid_q;
  logic signed [V-1:0] out_value_q;
  logic                out_run_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  eta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .action_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eta_dp #(
    .VALUE_BITS (VALUE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_value_i   ($signed(s_axis_tdata_i[V-1:0])),
    .end_value_i     ($signed(s_axis_tdata_i[O_END+V-1:O_END])),
    .span_ms_i       (s_axis_tdata_i[O_DUR+T-1:O_DUR]),
    .curve_i         (s_axis_tdata_i[O_CRV+2:O_CRV]),
    .loop_count_i    ($signed(s_axis_tdata_i[O_LC+8:O_LC])),
    .delta_ms_i      (s_axis_tdata_i[O_DT+T-1:O_DT]),
    .current_value_o (cur_value),
    .running_o       (running)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= cur_value;
      out_run_q   <= running;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'($unsigned(out_value_q));
  assign m_axis_tuser_o  = out_run_q;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased tween animator testbench
// Drives start and tick transactions with random handshake gaps, predicts
// each position and running flag from a behavioral tween model and checks
// every result transaction in order.
// ----------------------------------------------------------------------------
module tb_top;
  import eta_pkg::*;

  localparam int VB  = 32;
  localparam int TB  = 16;
  localparam int InW = ((2*VB + 2*TB + 12 + 7) / 8) * 8;
  localparam int OutW = ((VB + 7) / 8) * 8;
  localparam longint SPENT_TOP = (64'd1 << (TB + 2)) - 1;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] cur;
    logic        run;
  } pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [InW-1:0] s_data = '0;
  logic s_user = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OutW-1:0] m_data;
  logic m_user;

  eased_tween_animator i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longint tw_from, tw_to, tw_now, tw_len, tw_spent;
  int     tw_loops;
  logic [2:0] tw_curve;
  bit     tw_busy;
  pos_t   pos_queue[$];
  int     mismatches = 0;
  bit     gaps_on = 1'b1;
  int     ready_hold = 0;

  function automatic longint rnd_half(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint ease_of(logic [2:0] c, longint t);
    longint m, m2, m3, w;
    if (t == 0) return 0;
    if (t >= 65536) return 65536;
    case (c)
      CRV_IN_QUAD: return rnd_half(t * t, 16);
      CRV_OUT_QUAD: return rnd_half(t * (131072 - t), 16);
      CRV_INOUT_QUAD: begin
        if (t < 32768) return rnd_half(2 * t * t, 16);
        return rnd_half((262144 - 2 * t) * t, 16) - 65536;
      end
      CRV_OUT_CUBIC: begin
        m = 65536 - t;
        return 65536 - rnd_half(m * m * m, 32);
      end
      CRV_INOUT_CUBIC: begin
        if (t < 32768) return rnd_half(4 * t * t * t, 32);
        w = 131072 - 2 * t;
        return 65536 - rnd_half(w * w * w, 33);
      end
      CRV_OUT_BACK: begin
        m = 65536 - t;
        m2 = rnd_half(m * m, 16);
        m3 = rnd_half(m2 * m, 16);
        return 65536 - rnd_half(177051 * m3, 16) + rnd_half(111515 * m2, 16);
      end
      default: return t;
    endcase
  endfunction

  function automatic longint blend(longint a, longint b, longint e);
    longint d, dm, em, r, res;
    bit neg;
    d = b - a;
    neg = 1'b0;
    dm = d;
    em = e;
    if (d < 0) begin
      neg = ~neg;
      dm = -d;
    end
    if (e < 0) begin
      neg = ~neg;
      em = -e;
    end
    r = (dm >>> 16) * em + rnd_half((dm & 64'hFFFF) * em, 16);
    res = neg ? a - r : a + r;
    if (res > VMAX) res = VMAX;
    if (res < VMIN) res = VMIN;
    return res;
  endfunction

  function automatic pos_t tween_step(bit act, logic signed [31:0] sv,
                                      logic signed [31:0] ev, logic [15:0] dur,
                                      logic [2:0] crv, logic signed [8:0] lc,
                                      logic [15:0] dt);
    pos_t p;
    longint t;
    bit snapped;
    snapped = 1'b0;
    if (act == ACT_START) begin
      tw_from = longint'(sv);
      tw_to = longint'(ev);
      tw_now = tw_from;
      tw_len = (dur == 16'd0) ? 64'sd1 : longint'(dur);
      tw_spent = 0;
      tw_curve = crv;
      tw_loops = int'(lc);
      tw_busy = 1'b1;
    end else if (tw_busy) begin
      tw_spent += longint'(dt);
      if (tw_spent > SPENT_TOP) tw_spent = SPENT_TOP;
      if (tw_spent >= tw_len) begin
        if (tw_loops == 0) begin
          tw_now = tw_to;
          tw_busy = 1'b0;
          snapped = 1'b1;
        end else begin
          if (tw_loops > 0) tw_loops--;
          tw_spent -= tw_len;
          t = tw_from;
          tw_from = tw_to;
          tw_to = t;
        end
      end
      if (!snapped) begin
        t = (tw_spent <<< 16) / tw_len;
        if (t > 65536) t = 65536;
        tw_now = blend(tw_from, tw_to, ease_of(tw_curve, t));
      end
    end
    p.cur = tw_now[31:0];
    p.run = tw_busy;
    return p;
  endfunction

  task automatic send_item(bit act, logic [31:0] sv, logic [31:0] ev,
                           logic [15:0] dur, logic [2:0] crv, logic [8:0] lc,
                           logic [15:0] dt);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user <= act;
    s_data <= {{(InW - 108){1'b0}}, dt, lc, crv, dur, ev, sv};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    pos_queue.push_back(tween_step(act, sv, ev, dur, crv, lc, dt));
    @(negedge clk);
  endtask

  task automatic start_anim(logic [31:0] sv, logic [31:0] ev, logic [15:0] dur,
                            logic [2:0] crv, logic [8:0] lc);
    send_item(ACT_START, sv, ev, dur, crv, lc, 16'($urandom));
  endtask

  task automatic tick(logic [15:0] dt);
    send_item(ACT_TICK, $urandom, $urandom, 16'($urandom), 3'($urandom),
              9'($urandom), dt);
  endtask

  always @(posedge clk) begin
    pos_t want;
    if (m_valid && m_ready) begin
      if (pos_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", m_data, m_user);
      end else begin
        want = pos_queue.pop_front();
        if (m_data[31:0] !== want.cur || m_user !== want.run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b actual %h/%b",
                     want.cur, want.run, m_data[31:0], m_user);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      m_ready <= 1'b0;
      ready_hold--;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      m_ready <= 1'b0;
      ready_hold = $urandom_range(0, 3);
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic drain();
    s_valid <= 1'b0;
    do @(negedge clk); while (pos_queue.size() != 0);
  endtask

  task automatic test_idle_and_edges();
    tick(16'hFFFF);
    start_anim(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, CRV_LINEAR, 9'd0);
    tick(16'd0);
    tick(16'd1);
    start_anim(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 3'd7, 9'h1FF);
    tick(16'hFFFF);
    tick(16'hFFFF);
    tick(16'h8000);
    start_anim(32'h8000_0000, 32'h7FFF_FFFF, 16'd100, CRV_OUT_BACK, 9'd2);
    tick(16'd10);
    tick(16'd95);
    tick(16'd350);
    tick(16'd500);
    tick(16'd1);
    tick(16'd1);
  endtask

  task automatic test_curves();
    logic [2:0] c;
    for (int i = 0; i < 8; i++) begin
      c = 3'(i);
      start_anim(32'hFFF0_0000, 32'h0020_0000, 16'd64, c, 9'd1);
      repeat (6) tick(16'($urandom_range(5, 40)));
    end
    drain();
  endtask

  task automatic test_random(int n);
    int k;
    logic [8:0] lc;
    while (n > 0) begin
      case ($urandom_range(0, 3))
        0: lc = 9'h1FF;
        1: lc = 9'h100 | 9'($urandom);
        2: lc = 9'd0;
        default: lc = 9'($urandom_range(0, 255));
      endcase
      start_anim($urandom, $urandom,
                 ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 300)),
                 3'($urandom), lc);
      n--;
      k = $urandom_range(2, 14);
      for (int j = 0; j < k && n > 0; j++) begin
        tick(($urandom_range(0, 15) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, 120)));
        n--;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_idle_and_edges();
    test_curves();
    test_random(500);
    drain();
    gaps_on = 1'b0;
    test_random(150);
    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pos_queue.size() == 0) begin
      $display("PASS eased_tween_animator");
    end else begin
      $display("FAIL eased_tween_animator");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL eased_tween_animator");
    $finish;
  end

endmodule
